@@ hw/rtl/crc32rs_pkg.sv @@
// ----------------------------------------------------------------------------
// crc32rs_pkg
// Shared types, constants and CRC fold tables for the reflected CRC-32
// stream block.
// ----------------------------------------------------------------------------
package crc32rs_pkg;

  localparam int BYTES_PER_ITEM = 8;
  localparam int DATA_BYTES     = 8;
  localparam int CRC_W          = 32;
  localparam int BYTE_W         = 8;
  localparam int CNT_W          = $clog2(BYTES_PER_ITEM + 1);
  localparam int QUEUE_DEPTH    = 2;
  localparam int QPTR_W         = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W         = $clog2(QUEUE_DEPTH + 1);

  localparam logic [CRC_W-1:0] CRC_POLY = 32'hEDB88320;

  // Input word as it arrives on the item channel.
  typedef struct packed {
    logic                        start_req;
    logic [CRC_W-1:0]            start_crc;
    logic [DATA_BYTES*BYTE_W-1:0] data_bytes;
    logic [3:0]                  byte_count;
    logic                        last;
  } in_word_t;

  // Result word on the result channel.
  typedef struct packed {
    logic [CRC_W-1:0] crc_value;
    logic             is_last;
  } out_word_t;

  // Classified item held in the queue between front and back.
  typedef struct packed {
    logic             start_req;
    logic [CRC_W-1:0] start_crc;
    logic [CNT_W-1:0] nbytes;
    logic [CRC_W-1:0] data_fold;
    logic             last;
  } qent_t;

  // Column k of table m is the register after m zero bytes are folded into
  // a register that holds only bit k.
  typedef logic [BYTES_PER_ITEM:0][CRC_W-1:0][CRC_W-1:0] col_tab_t;

  function automatic logic [CRC_W-1:0] zero_fold(logic [CRC_W-1:0] crc_in,
                                                 int unsigned nbytes);
    logic [CRC_W-1:0] crc;
    crc = crc_in;
    for (int unsigned s = 0; s < nbytes * BYTE_W; s++) begin
      crc = crc[0] ? (CRC_POLY ^ (crc >> 1)) : (crc >> 1);
    end
    return crc;
  endfunction

  function automatic col_tab_t gen_col_tab();
    col_tab_t tab;
    for (int m = 0; m <= BYTES_PER_ITEM; m++) begin
      for (int k = 0; k < CRC_W; k++) begin
        tab[m][k] = zero_fold(CRC_W'(1) << k, m);
      end
    end
    return tab;
  endfunction

  localparam col_tab_t COL_TAB = gen_col_tab();

  // Linear map: fold nbytes zero bytes into register value v.
  function automatic logic [CRC_W-1:0] apply_fold(logic [CRC_W-1:0] v,
                                                  logic [CNT_W-1:0] nbytes);
    logic [CRC_W-1:0] acc;
    acc = '0;
    for (int k = 0; k < CRC_W; k++) begin
      if (v[k]) begin
        acc = acc ^ COL_TAB[nbytes][k];
      end
    end
    return acc;
  endfunction

endpackage

@@ hw/rtl/crc32_reflected_stream.sv @@
// ----------------------------------------------------------------------------
// crc32_reflected_stream
// Running reflected CRC-32 (polynomial 0xEDB88320) over up to eight bytes
// per word.
// ----------------------------------------------------------------------------
// The block takes one word per clock while the input is not stalled and
// gives one result word per input word, in order. A result word passes
// from the queue into the result register before it is presented. While
// the result channel stalls, up to three words wait inside (two in the
// queue and one in the result register) before the input is stalled. The
// throughput of one word per cycle, when the result channel is not stalled,
// is set by the feedback path of the running register, which goes through
// one 32-bit zero-byte fold matrix and an XOR as combinational logic.
// Bytes are packed little-endian: the first message byte sits in bits 7:0
// of data_bytes, and byte_count says how many bytes from the low end are
// valid (counts above eight are treated as eight, and zero folds nothing).
// When start_req is set, the running register is first loaded from
// start_crc. The raw register is returned after every word; there is no
// initial or final inversion, so the caller seeds with all ones and inverts
// the final value for standard CRC-32. The last flag is only copied to
// is_last and does not reset the running register.
// ----------------------------------------------------------------------------
module crc32_reflected_stream (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   item_valid,
  output logic                   item_stall,
  input  crc32rs_pkg::in_word_t  item,
  output logic                   result_valid,
  input  logic                   result_stall,
  output crc32rs_pkg::out_word_t result
);

  // The front folds the message bytes as if the register were zero. By
  // linearity of the CRC, the back then only has to fold the running
  // register through the same number of zero bytes and XOR the two.
  logic               wr_en;
  crc32rs_pkg::qent_t wr_entry;
  logic               full;
  logic               rd_en;
  logic               rd_valid;
  crc32rs_pkg::qent_t rd_entry;

  crc32rs_front u_front (
    .item_valid (item_valid),
    .item_stall (item_stall),
    .item       (item),
    .wr_en      (wr_en),
    .wr_entry   (wr_entry),
    .full       (full)
  );

  // Two entries let the front keep accepting while the back waits on a
  // stalled result register.
  crc32rs_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (wr_en),
    .wr_entry (wr_entry),
    .full     (full),
    .rd_en    (rd_en),
    .rd_valid (rd_valid),
    .rd_entry (rd_entry)
  );

  crc32rs_back u_back (
    .clk          (clk),
    .rst          (rst),
    .rd_valid     (rd_valid),
    .rd_entry     (rd_entry),
    .rd_en        (rd_en),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

endmodule

@@ hw/rtl/crc32rs_front.sv @@
// ----------------------------------------------------------------------------
// crc32rs_front
// Accepts words, clamps the byte count and folds the message bytes into
// their share of the CRC, which does not depend on the running register.
// ----------------------------------------------------------------------------
module crc32rs_front (
  input  logic                  item_valid,
  output logic                  item_stall,
  input  crc32rs_pkg::in_word_t item,
  output logic                  wr_en,
  output crc32rs_pkg::qent_t    wr_entry,
  input  logic                  full
);

  logic [crc32rs_pkg::CNT_W-1:0] nbytes;
  logic [crc32rs_pkg::CRC_W-1:0] fold;

  always_comb begin
    if ({1'b0, item.byte_count} > 5'(crc32rs_pkg::BYTES_PER_ITEM)) begin
      nbytes = crc32rs_pkg::CNT_W'(crc32rs_pkg::BYTES_PER_ITEM);
    end else begin
      nbytes = crc32rs_pkg::CNT_W'(item.byte_count);
    end
  end

  // Byte i enters the register and is followed by (nbytes - i) byte shifts.
  always_comb begin
    fold = '0;
    for (int i = 0; i < crc32rs_pkg::DATA_BYTES; i++) begin
      if (i < int'(nbytes)) begin
        fold = fold ^ crc32rs_pkg::apply_fold(
                 crc32rs_pkg::CRC_W'(item.data_bytes[i*crc32rs_pkg::BYTE_W +:
                                                     crc32rs_pkg::BYTE_W]),
                 nbytes - crc32rs_pkg::CNT_W'(i));
      end
    end
  end

  assign item_stall = full;
  assign wr_en      = item_valid && !full;

  always_comb begin
    wr_entry.start_req = item.start_req;
    wr_entry.start_crc = item.start_crc;
    wr_entry.nbytes    = nbytes;
    wr_entry.data_fold = fold;
    wr_entry.last      = item.last;
  end

endmodule

@@ hw/rtl/crc32rs_queue.sv @@
// ----------------------------------------------------------------------------
// crc32rs_queue
// Short FIFO of classified items between the front and the back.
// ----------------------------------------------------------------------------
module crc32rs_queue (
  input  logic               clk,
  input  logic               rst,
  input  logic               wr_en,
  input  crc32rs_pkg::qent_t wr_entry,
  output logic               full,
  input  logic               rd_en,
  output logic               rd_valid,
  output crc32rs_pkg::qent_t rd_entry
);

  crc32rs_pkg::qent_t              slots [crc32rs_pkg::QUEUE_DEPTH];
  logic [crc32rs_pkg::QPTR_W-1:0]  wr_ptr;
  logic [crc32rs_pkg::QPTR_W-1:0]  rd_ptr;
  logic [crc32rs_pkg::QCNT_W-1:0]  count;

  localparam logic [crc32rs_pkg::QPTR_W-1:0] LAST_PTR =
    crc32rs_pkg::QPTR_W'(crc32rs_pkg::QUEUE_DEPTH - 1);

  assign full     = (count == crc32rs_pkg::QCNT_W'(crc32rs_pkg::QUEUE_DEPTH));
  assign rd_valid = (count != '0);
  assign rd_entry = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      slots[wr_ptr] <= wr_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + 1'b1;
      end
      if (rd_en) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + 1'b1;
      end
      if (wr_en && !rd_en) begin
        count <= count + 1'b1;
      end else if (rd_en && !wr_en) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

@@ hw/rtl/crc32rs_back.sv @@
// ----------------------------------------------------------------------------
// crc32rs_back
// Holds the running CRC, combines it with each queued item's data share and
// presents the result in an output register.
// ----------------------------------------------------------------------------
module crc32rs_back (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   rd_valid,
  input  crc32rs_pkg::qent_t     rd_entry,
  output logic                   rd_en,
  output logic                   result_valid,
  input  logic                   result_stall,
  output crc32rs_pkg::out_word_t result
);

  logic [crc32rs_pkg::CRC_W-1:0] running_crc;
  logic [crc32rs_pkg::CRC_W-1:0] base_crc;
  logic [crc32rs_pkg::CRC_W-1:0] crc_next;

  assign rd_en = rd_valid && (!result_valid || !result_stall);

  always_comb begin
    base_crc = rd_entry.start_req ? rd_entry.start_crc : running_crc;
    crc_next = crc32rs_pkg::apply_fold(base_crc, rd_entry.nbytes) ^ rd_entry.data_fold;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running_crc  <= '0;
      result_valid <= 1'b0;
    end else if (rd_en) begin
      running_crc  <= crc_next;
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      result.crc_value <= crc_next;
      result.is_last   <= rd_entry.last;
    end
  end

endmodule

@@ hw/rtl/crc32rs_checker.sv @@
// ----------------------------------------------------------------------------
// crc32rs_checker
// Port-level checks for the CRC stream block, bound to the top level.
// ----------------------------------------------------------------------------
module crc32rs_checker (
  input logic                   clk,
  input logic                   rst,
  input logic                   item_valid,
  input logic                   item_stall,
  input crc32rs_pkg::in_word_t  item,
  input logic                   result_valid,
  input logic                   result_stall,
  input crc32rs_pkg::out_word_t result
);

  localparam int MAX_PEND = crc32rs_pkg::QUEUE_DEPTH + 1;

  logic [$clog2(MAX_PEND + 2)-1:0] pending;
  logic                            item_take;
  logic                            result_take;

  assign item_take   = item_valid && !item_stall;
  assign result_take = result_valid && !result_stall;

  // Words taken but not yet delivered.
  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= '0;
    end else if (item_take && !result_take) begin
      pending <= pending + 1'b1;
    end else if (result_take && !item_take) begin
      pending <= pending - 1'b1;
    end
  end

  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(result))
    else $error("result word changed while stalled");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !result_valid)
    else $error("result valid right after reset");

  a_no_invented: assert property (@(posedge clk) disable iff (rst)
    result_take |-> pending != '0)
    else $error("result delivered with no word outstanding");

  a_stall_busy: assert property (@(posedge clk) disable iff (rst)
    item_stall |-> pending != '0)
    else $error("input stalled with nothing in flight");

  a_pending_bound: assert property (@(posedge clk) disable iff (rst)
    int'(pending) <= MAX_PEND)
    else $error("more words in flight than storage allows");

endmodule

bind crc32_reflected_stream crc32rs_checker u_checker (.*);
